### rtl/core/positional_sequence_store_core_defines.svh
// Assertion macros for the sequence store checker
`ifndef POSITIONAL_SEQUENCE_STORE_CORE_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_CORE_DEFINES_SVH

// Clocked assertion with reset disable
`define PSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked only when an output item is shown
`define PSS_ASSERT_OUT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    m_axis_tvalid_o |-> (cond)) else $error(msg);

`endif

### rtl/core/pss_pkg.sv
// Shared constants, codes and helpers for the sequence store
`timescale 1ns / 1ps
`default_nettype none
package pss_pkg;
  localparam int unsigned Capacity  = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrW     = $clog2(Capacity);
  localparam int unsigned CountW    = AddrW + 1;

  typedef enum logic [2:0] {
    KIND_INSERT  = 3'd0,
    KIND_REMOVE  = 3'd1,
    KIND_READ    = 3'd2,
    KIND_SEARCH  = 3'd3,
    KIND_REVERSE = 3'd4,
    KIND_SUMMARY = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                            input logic rev,
                                            input logic [AddrW-1:0] idx);
    phys = rev ? head - idx : head + idx;
  endfunction
endpackage
`default_nettype wire

### rtl/core/pss_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module pss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/positional_sequence_store_core.sv
// Top level of the positional sequence store
// Bounded double-ended sequence of 64 signed 32-bit words held in one RAM with a
// registered read. One request is handled at a time and gives one result
// item. Reverse, insert at either end, full inserts and out-of-range or empty
// requests go straight to the output handshake. Read and end removes read one
// entry. Interior insert, interior remove, search and summarize walk the stored
// entries through the single RAM read port, one entry per cycle. The store needs
// no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
module positional_sequence_store_core
  import pss_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [39:0]  s_axis_tdata_i,  // position[6:0], value[38:7], zero pad
  input  wire logic [2:0]   s_axis_tuser_i,  // kind[2:0]
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic      [111:0] m_axis_tdata_o,  // value_out[31:0], found[32],
                                              // element_count[39:33], min_value[71:40],
                                              // max_value[103:72], nondecreasing[104],
                                              // nonincreasing[105], zero pad
  output logic      [1:0]   m_axis_tuser_o   // status[1:0]
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_FILL = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0]     head_q, head_d;
  logic [CountW-1:0]    count_q, count_d;
  logic                 rev_q, rev_d;
  kind_e                kind_q, kind_d;
  logic [CountW-1:0]    pos_q, pos_d, end_q, end_d, rp_q, rp_d, dp_q, dp_d;
  logic                 down_q, down_d, iss_q, iss_d, dv_q, dv_d;
  logic [DataWidth-1:0] val_q, val_d, vout_q, vout_d, mn_q, mn_d, mx_q, mx_d, prev_q, prev_d;
  logic                 found_q, found_d, ndec_q, ndec_d, ninc_q, ninc_d;
  status_e              status_q, status_d;

  logic                 we;
  logic [AddrW-1:0]     waddr, raddr;
  logic [DataWidth-1:0] wdata, rdata;

  logic [2:0]           in_kind;
  logic [CountW-1:0]    in_pos, cnt_m1, rm_p;
  logic [DataWidth-1:0] in_val;
  logic                 accept;

  assign in_kind = s_axis_tuser_i;
  assign in_pos  = s_axis_tdata_i[6:0];
  assign in_val  = s_axis_tdata_i[38:7];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_m1  = count_q - CountW'(1);
  assign rm_p    = (in_pos == '0) ? '0 : ((in_pos >= cnt_m1) ? cnt_m1 : in_pos);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {6'b0, ninc_q, ndec_q, mx_q, mn_q, count_q, found_q, vout_q};

  assign raddr = phys(head_q, rev_q, rp_q[AddrW-1:0]);

  pss_ram #(.Width(DataWidth), .Depth(Capacity)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    rev_d    = rev_q;
    kind_d   = kind_q;
    pos_d    = pos_q;
    end_d    = end_q;
    down_d   = down_q;
    val_d    = val_q;
    vout_d   = vout_q;
    mn_d     = mn_q;
    mx_d     = mx_q;
    prev_d   = prev_q;
    found_d  = found_q;
    ndec_d   = ndec_q;
    ninc_d   = ninc_q;
    status_d = status_q;
    rp_d     = rp_q;
    iss_d    = 1'b0;
    dv_d     = 1'b0;
    dp_d     = rp_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d   = kind_e'(in_kind);
          val_d    = in_val;
          pos_d    = in_pos;
          vout_d   = '0;
          mn_d     = '0;
          mx_d     = '0;
          found_d  = 1'b0;
          ndec_d   = 1'b0;
          ninc_d   = 1'b0;
          status_d = ST_OK;
          down_d   = 1'b0;
          state_d  = S_OUT;
          unique case (in_kind)
            KIND_INSERT: begin
              priority if (count_q >= CountW'(Capacity)) begin
                status_d = ST_FULL;
              end else if (in_pos == '0) begin
                head_d  = rev_q ? head_q + AddrW'(1) : head_q - AddrW'(1);
                we      = 1'b1;
                waddr   = head_d;
                wdata   = in_val;
                count_d = count_q + CountW'(1);
              end else if (in_pos >= count_q) begin
                we      = 1'b1;
                waddr   = phys(head_q, rev_q, count_q[AddrW-1:0]);
                wdata   = in_val;
                count_d = count_q + CountW'(1);
              end else begin
                rp_d    = cnt_m1;
                end_d   = in_pos;
                down_d  = 1'b1;
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            KIND_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                pos_d   = rm_p;
                rp_d    = rm_p;
                end_d   = (rm_p == '0) ? '0 : cnt_m1;
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            KIND_READ: begin
              priority if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (in_pos >= count_q) begin
                status_d = ST_RANGE;
              end else begin
                rp_d    = in_pos;
                end_d   = in_pos;
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            KIND_SEARCH: begin
              if (count_q != '0) begin
                rp_d    = '0;
                end_d   = cnt_m1;
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            KIND_REVERSE: begin
              if (count_q != '0) begin
                head_d = phys(head_q, rev_q, cnt_m1[AddrW-1:0]);
              end
              rev_d = !rev_q;
            end
            KIND_SUMMARY: begin
              ndec_d = 1'b1;
              ninc_d = 1'b1;
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                rp_d    = '0;
                end_d   = cnt_m1;
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        iss_d = iss_q && (rp_q != end_q);
        if (iss_q) begin
          rp_d = down_q ? rp_q - CountW'(1) : rp_q + CountW'(1);
        end
        dv_d = iss_q;
        dp_d = rp_q;
        if (dv_q) begin
          unique case (kind_q)
            KIND_INSERT: begin
              we    = 1'b1;
              waddr = phys(head_q, rev_q, dp_q[AddrW-1:0] + AddrW'(1));
              wdata = rdata;
              if (dp_q == end_q) state_d = S_FILL;
            end
            KIND_REMOVE: begin
              if (dp_q == pos_q) begin
                vout_d = rdata;
              end else begin
                we    = 1'b1;
                waddr = phys(head_q, rev_q, dp_q[AddrW-1:0] - AddrW'(1));
                wdata = rdata;
              end
              if (dp_q == end_q) begin
                count_d = cnt_m1;
                if (pos_q == '0) begin
                  head_d = rev_q ? head_q - AddrW'(1) : head_q + AddrW'(1);
                end
                state_d = S_OUT;
              end
            end
            KIND_READ: begin
              vout_d  = rdata;
              state_d = S_OUT;
            end
            KIND_SEARCH: begin
              if (rdata == val_q) found_d = 1'b1;
              if (dp_q == end_q) state_d = S_OUT;
            end
            default: begin
              prev_d = rdata;
              if (dp_q == '0) begin
                mn_d = rdata;
                mx_d = rdata;
              end else begin
                if ($signed(rdata) < $signed(mn_q)) mn_d = rdata;
                if ($signed(rdata) > $signed(mx_q)) mx_d = rdata;
                if ($signed(rdata) < $signed(prev_q)) ndec_d = 1'b0;
                if ($signed(rdata) > $signed(prev_q)) ninc_d = 1'b0;
              end
              if (dp_q == end_q) state_d = S_OUT;
            end
          endcase
        end
      end
      S_FILL: begin
        we      = 1'b1;
        waddr   = phys(head_q, rev_q, pos_q[AddrW-1:0]);
        wdata   = val_q;
        count_d = count_q + CountW'(1);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
      iss_q   <= 1'b0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      iss_q   <= iss_d;
      dv_q    <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    pos_q    <= pos_d;
    end_q    <= end_d;
    down_q   <= down_d;
    rp_q     <= rp_d;
    dp_q     <= dp_d;
    val_q    <= val_d;
    vout_q   <= vout_d;
    mn_q     <= mn_d;
    mx_q     <= mx_d;
    prev_q   <= prev_d;
    found_q  <= found_d;
    ndec_q   <= ndec_d;
    ninc_q   <= ninc_d;
    status_q <= status_d;
  end
endmodule
`default_nettype wire

### rtl/core/pss_checker.sv
// Port-level checker for the sequence store, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "positional_sequence_store_core_defines.svh"
module pss_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [111:0] m_axis_tdata_o,
  input wire logic [1:0]   m_axis_tuser_o
);
  `PSS_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "output item changed while stalled")
  `PSS_ASSERT_OUT(a_count_max, m_axis_tdata_o[39:33] <= 7'd64, "element count beyond capacity")
  `PSS_ASSERT_OUT(a_full_count, m_axis_tuser_o != 2'd2 || m_axis_tdata_o[39:33] == 7'd64, "full status with room left")
  `PSS_ASSERT_OUT(a_empty_count, m_axis_tuser_o != 2'd1 || m_axis_tdata_o[39:33] == 7'd0, "empty status with elements stored")
  `PSS_ASSERT(a_one_side, m_axis_tvalid_o |-> !s_axis_tready_o, "input taken while a result waits")
endmodule

bind positional_sequence_store_core pss_checker u_pss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the positional sequence store: directed table then random requests
`timescale 1ns / 1ps
module testbench;
  import pss_pkg::*;

  typedef struct packed {
    logic [31:0] value_out;
    status_e     status;
    logic        found;
    logic [6:0]  count;
    logic [31:0] min_value;
    logic [31:0] max_value;
    logic        nondecr;
    logic        nonincr;
  } outcome_t;

  typedef struct {
    logic [2:0]  kind;
    logic [6:0]  pos;
    logic [31:0] value;
    bit          typed;
    outcome_t    outcome;
  } request_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [39:0]  s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  positional_sequence_store_core DUT (.*);

  int          contents[$];
  outcome_t    pending[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  bit          failed = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic outcome_t apply_request(logic [2:0] kind, logic [6:0] pos,
                                             logic [31:0] value);
    outcome_t o;
    int sz;
    int cur;
    o = '0;
    o.status = ST_OK;
    sz = contents.size();
    case (kind)
      KIND_INSERT: begin
        if (sz >= Capacity) o.status = ST_FULL;
        else if (pos == 0) contents.push_front(value);
        else if (pos >= sz) contents.push_back(value);
        else contents.insert(pos, value);
      end
      KIND_REMOVE: begin
        if (sz == 0) o.status = ST_EMPTY;
        else if (pos == 0) o.value_out = contents.pop_front();
        else if (pos >= sz - 1) o.value_out = contents.pop_back();
        else begin
          o.value_out = contents[pos];
          contents.delete(pos);
        end
      end
      KIND_READ: begin
        if (sz == 0) o.status = ST_EMPTY;
        else if (pos >= sz) o.status = ST_RANGE;
        else o.value_out = contents[pos];
      end
      KIND_SEARCH: begin
        foreach (contents[i]) if (contents[i] == $signed(value)) o.found = 1'b1;
      end
      KIND_REVERSE: contents.reverse();
      KIND_SUMMARY: begin
        o.nondecr = 1'b1;
        o.nonincr = 1'b1;
        if (sz == 0) o.status = ST_EMPTY;
        else begin
          o.min_value = contents[0];
          o.max_value = contents[0];
          for (int i = 1; i < sz; i++) begin
            cur = contents[i];
            if (cur < $signed(o.min_value)) o.min_value = cur;
            if (cur > $signed(o.max_value)) o.max_value = cur;
            if (cur < contents[i-1]) o.nondecr = 1'b0;
            if (cur > contents[i-1]) o.nonincr = 1'b0;
          end
        end
      end
      default: ;
    endcase
    o.count = 7'(contents.size());
    return o;
  endfunction

  task automatic send_request(request_t r);
    outcome_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, r.value, r.pos};
    s_axis_tuser_i  <= r.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_request(r.kind, r.pos, r.value);
    pending.push_back(r.typed ? r.outcome : predicted);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    outcome_t exp_o;
    outcome_t got;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else if (rst_ni)
      quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.value_out = m_axis_tdata_o[31:0];
      got.status    = status_e'(m_axis_tuser_o);
      got.found     = m_axis_tdata_o[32];
      got.count     = m_axis_tdata_o[39:33];
      got.min_value = m_axis_tdata_o[71:40];
      got.max_value = m_axis_tdata_o[103:72];
      got.nondecr   = m_axis_tdata_o[104];
      got.nonincr   = m_axis_tdata_o[105];
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        failed = 1;
      end else begin
        exp_o = pending.pop_front();
        if (got.value_out !== exp_o.value_out) begin
          $error("value_out: expected %0d, got %0d", $signed(exp_o.value_out),
                 $signed(got.value_out));
          failed = 1;
        end
        if (got.status !== exp_o.status) begin
          $error("status: expected %0d, got %0d", exp_o.status, got.status);
          failed = 1;
        end
        if (got.found !== exp_o.found) begin
          $error("found: expected %0d, got %0d", exp_o.found, got.found);
          failed = 1;
        end
        if (got.count !== exp_o.count) begin
          $error("element_count: expected %0d, got %0d", exp_o.count, got.count);
          failed = 1;
        end
        if (got.min_value !== exp_o.min_value) begin
          $error("min_value: expected %0d, got %0d", $signed(exp_o.min_value),
                 $signed(got.min_value));
          failed = 1;
        end
        if (got.max_value !== exp_o.max_value) begin
          $error("max_value: expected %0d, got %0d", $signed(exp_o.max_value),
                 $signed(got.max_value));
          failed = 1;
        end
        if (got.nondecr !== exp_o.nondecr) begin
          $error("nondecreasing: expected %0d, got %0d", exp_o.nondecr, got.nondecr);
          failed = 1;
        end
        if (got.nonincr !== exp_o.nonincr) begin
          $error("nonincreasing: expected %0d, got %0d", exp_o.nonincr, got.nonincr);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= 3000) begin
      $display("positional_sequence_store_core: mismatch");
      $finish;
    end
  end

  function automatic request_t row(logic [2:0] kind, logic [6:0] pos, logic [31:0] value,
                                   bit typed, logic [31:0] vout, status_e st,
                                   logic [6:0] cnt, logic nd, logic ni);
    request_t r;
    r.kind = kind;
    r.pos = pos;
    r.value = value;
    r.typed = typed;
    r.outcome = '0;
    r.outcome.value_out = vout;
    r.outcome.status = st;
    r.outcome.count = cnt;
    r.outcome.nondecr = nd;
    r.outcome.nonincr = ni;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(2))
      0: return $urandom;
      1: return $urandom_range(8) - 4;
      default: return contents.size() ? contents[$urandom_range(contents.size() - 1)]
                                      : $urandom;
    endcase
  endfunction

  initial begin
    request_t directed[$];
    request_t r;
    bit filling;
    int unsigned roll;
    int unsigned sz;

    directed = '{
      row(KIND_REMOVE,  7'd0,   32'd0,         1, 32'd0, ST_EMPTY, 7'd0, 0, 0),
      row(KIND_READ,    7'd0,   32'd0,         1, 32'd0, ST_EMPTY, 7'd0, 0, 0),
      row(KIND_SUMMARY, 7'd0,   32'd0,         1, 32'd0, ST_EMPTY, 7'd0, 1, 1),
      row(KIND_SEARCH,  7'd0,   32'd0,         1, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_REVERSE, 7'd0,   32'd0,         1, 32'd0, ST_OK,    7'd0, 0, 0),
      row(3'd6,         7'd127, 32'hFFFFFFFF,  1, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_INSERT,  7'd0,   32'h80000000,  1, 32'd0, ST_OK,    7'd1, 0, 0),
      row(KIND_SUMMARY, 7'd0,   32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_INSERT,  7'd127, 32'h7FFFFFFF,  1, 32'd0, ST_OK,    7'd2, 0, 0),
      row(KIND_INSERT,  7'd1,   32'd5,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_INSERT,  7'd3,   32'hFFFFFFFF,  0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_READ,    7'd0,   32'd0,         1, 32'h80000000, ST_OK, 7'd4, 0, 0),
      row(KIND_READ,    7'd64,  32'd0,         1, 32'd0, ST_RANGE, 7'd4, 0, 0),
      row(KIND_READ,    7'd4,   32'd0,         1, 32'd0, ST_RANGE, 7'd4, 0, 0),
      row(KIND_SUMMARY, 7'd0,   32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_SEARCH,  7'd0,   32'd5,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_SEARCH,  7'd0,   32'd6,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_REVERSE, 7'd0,   32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_READ,    7'd1,   32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_REMOVE,  7'd1,   32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_REMOVE,  7'd127, 32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_REMOVE,  7'd0,   32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(3'd7,         7'd0,   32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0),
      row(KIND_SUMMARY, 7'd0,   32'd0,         0, 32'd0, ST_OK,    7'd0, 0, 0)
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 36;
    recv_stall_pct = 47;
    foreach (directed[i]) send_request(directed[i]);

    filling = 1;
    for (int n = 0; n < 1700; n++) begin
      if (n == 567) begin
        send_idle_pct = 47;
        recv_stall_pct = 36;
      end else if (n == 1134) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      sz = contents.size();
      if (sz >= Capacity || $urandom_range(99) < 2) filling = 0;
      if (sz == 0 || $urandom_range(99) < 2) filling = 1;
      roll = $urandom_range(99);
      r.typed = 0;
      r.outcome = '0;
      if (roll < (filling ? 60 : 20)) r.kind = KIND_INSERT;
      else if (roll < 70) r.kind = KIND_REMOVE;
      else if (roll < 80) r.kind = KIND_READ;
      else if (roll < 87) r.kind = KIND_SEARCH;
      else if (roll < 91) r.kind = KIND_REVERSE;
      else if (roll < 98) r.kind = KIND_SUMMARY;
      else r.kind = 3'($urandom_range(7, 6));
      r.pos = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(sz + 1));
      r.value = pick_value();
      send_request(r);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("positional_sequence_store_core: match");
    end else begin
      $display("positional_sequence_store_core: mismatch");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/pss_pkg.sv
rtl/core/pss_ram.sv
rtl/core/positional_sequence_store_core.sv
rtl/core/pss_checker.sv
bench/testbench.sv
